// ===== rtl/p2c_pkg.sv =====
// shared types, constants and the pixel unpack function of the planar to chunky blitter
package p2c_pkg;

   localparam int ADDR_W     = 24;
   localparam int LB_W       = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   // job queue between classifier and writer
   localparam int QDEPTH = 2;
   localparam int PTR_W  = 1;
   localparam int LVL_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_OFFSET = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES   = 4'd1;

   localparam logic [LB_W-1:0] LINE_BYTES_RESET = 12'd320;

   typedef struct packed {
      logic [31:0]       plane_pair_a;
      logic [31:0]       plane_pair_b;
      logic [ADDR_W-1:0] line_offset;
      logic [ADDR_W-1:0] col_offset;
   } p2c_job_type;

   typedef struct packed {
      logic        valid;
      p2c_job_type job;
   } p2c_push_type;

   // four chunky pixels of word `word`, leftmost pixel in the top byte
   function automatic logic [31:0] chunky_quad(input logic [31:0] a, input logic [31:0] b,
                                               input logic [1:0] word);
      logic [31:0] quad;
      int          p;
      int          s;
      quad = '0;
      for (int i = 0; i < 4; i++) begin
         p = int'(word) * 4 + i;
         s = 15 - p;
         quad[8*(3-i) +: 4] = {b[s], b[16+s], a[s], a[16+s]};
      end
      return quad;
   endfunction

endpackage

// ===== rtl/p2c_if.sv =====
// channel interfaces: chunk input, pixel word output and register write port
interface p2c_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] plane_pair_a;
   logic [31:0] plane_pair_b;
   logic        frame_start;
   modport source(output valid, plane_pair_a, plane_pair_b, frame_start, input ready);
   modport sink(input valid, plane_pair_a, plane_pair_b, frame_start, output ready);
endinterface

interface p2c_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [p2c_pkg::ADDR_W-1:0] byte_address;
   logic [31:0]                pixel_quad;
   logic                       last_word;
   modport source(output valid, byte_address, pixel_quad, last_word, input ready);
   modport sink(input valid, byte_address, pixel_quad, last_word, output ready);
endinterface

interface p2c_csr_if;
   logic                           valid;
   logic                           ready;
   logic [p2c_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [p2c_pkg::CSR_DATA_W-1:0] write_data;
   modport source(output valid, reg_index, write_data, input ready);
   modport sink(input valid, reg_index, write_data, output ready);
endinterface

// ===== rtl/p2c_ram.sv =====
// generic single write port ram with registered read
module p2c_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4000
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/p2c_front.sv =====
// front end: chunk position tracking, history lookup and change detection
module p2c_front #(
   parameter int CHUNKS_PER_LINE = 20,
   parameter int LINES           = 200
) (
   input  logic                          clock,
   input  logic                          reset,
   p2c_req_if.sink                       req,
   input  logic [p2c_pkg::LB_W-1:0]      line_bytes,
   input  logic [p2c_pkg::LVL_W-1:0]     queue_level,
   output p2c_pkg::p2c_push_type         push
);

   localparam int HIST_DEPTH = CHUNKS_PER_LINE * LINES;
   localparam int IDX_W  = HIST_DEPTH > 1 ? $clog2(HIST_DEPTH) : 1;
   localparam int FILL_W = $clog2(HIST_DEPTH + 1);
   localparam int COL_W  = CHUNKS_PER_LINE > 1 ? $clog2(CHUNKS_PER_LINE) : 1;
   localparam int LINE_W = LINES > 1 ? $clog2(LINES) : 1;
   localparam int SUM_W  = p2c_pkg::LVL_W + 1;

   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(CHUNKS_PER_LINE - 1);
   localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HIST_DEPTH);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [LINE_W-1:0] s1_line_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [63:0]       s1_chunk_ff;

   logic              prev_valid_ff;
   logic [IDX_W-1:0]  prev_idx_ff;
   logic [63:0]       prev_chunk_ff;

   logic              fire;
   logic [COL_W-1:0]  cur_col;
   logic [LINE_W-1:0] cur_line;
   logic [IDX_W-1:0]  cur_idx;
   logic              col_wrap;
   logic              line_wrap;
   logic [63:0]       rd_data;
   logic [63:0]       hist;
   logic              prev_hit;
   logic              filled;
   logic              changed;
   logic [LINE_W+p2c_pkg::LB_W-1:0] line_prod;

   // room for the item in flight plus this one
   assign req.ready = (SUM_W'(queue_level) + SUM_W'(s1_valid_ff)) < SUM_W'(p2c_pkg::QDEPTH);
   assign fire      = req.valid && req.ready;

   assign cur_col   = req.frame_start ? '0 : col_ff;
   assign cur_line  = req.frame_start ? '0 : line_ff;
   assign cur_idx   = req.frame_start ? '0 : idx_ff;
   assign col_wrap  = cur_col == COL_LAST;
   assign line_wrap = cur_line == LINE_LAST;

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      idx_in  = idx_ff;
      if (fire) begin
         col_in  = col_wrap ? '0 : COL_W'(cur_col + 1'b1);
         line_in = !col_wrap ? cur_line : (line_wrap ? '0 : LINE_W'(cur_line + 1'b1));
         idx_in  = (col_wrap && line_wrap) ? '0 : IDX_W'(cur_idx + 1'b1);
      end
   end

   p2c_ram #(
      .WIDTH(64),
      .DEPTH(HIST_DEPTH)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(s1_idx_ff),
      .wr_data(s1_chunk_ff),
      .rd_en  (fire),
      .rd_addr(cur_idx),
      .rd_data(rd_data)
   );

   // entries at or past the fill mark were never written and read as zero
   assign prev_hit = prev_valid_ff && (prev_idx_ff == s1_idx_ff);
   assign filled   = FILL_W'(s1_idx_ff) < fill_ff;
   assign hist     = prev_hit ? prev_chunk_ff : (filled ? rd_data : '0);
   assign changed  = hist != s1_chunk_ff;

   always_comb begin
      fill_in = fill_ff;
      if (s1_valid_ff && (FILL_W'(s1_idx_ff) == fill_ff) && (fill_ff != FILL_FULL)) begin
         fill_in = FILL_W'(fill_ff + 1'b1);
      end
   end

   assign line_prod = s1_line_ff * line_bytes;

   always_comb begin
      push.valid            = s1_valid_ff && changed;
      push.job.plane_pair_a = s1_chunk_ff[63:32];
      push.job.plane_pair_b = s1_chunk_ff[31:0];
      push.job.line_offset  = p2c_pkg::ADDR_W'(line_prod);
      push.job.col_offset   = p2c_pkg::ADDR_W'({s1_col_ff, 4'b0000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         line_ff       <= '0;
         idx_ff        <= '0;
         fill_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         line_ff     <= line_in;
         idx_ff      <= idx_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= fire;
         if (s1_valid_ff) begin
            prev_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_idx_ff   <= cur_idx;
         s1_line_ff  <= cur_line;
         s1_col_ff   <= cur_col;
         s1_chunk_ff <= {req.plane_pair_a, req.plane_pair_b};
      end
      if (s1_valid_ff) begin
         prev_idx_ff   <= s1_idx_ff;
         prev_chunk_ff <= s1_chunk_ff;
      end
   end

endmodule

// ===== rtl/p2c_fifo.sv =====
// short job queue between front and back end
module p2c_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  p2c_pkg::p2c_push_type     push,
   input  logic                      pop,
   output logic                      head_valid,
   output p2c_pkg::p2c_job_type      head,
   output logic [p2c_pkg::LVL_W-1:0] level
);

   p2c_pkg::p2c_job_type            mem_ff [p2c_pkg::QDEPTH];
   logic [p2c_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [p2c_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [p2c_pkg::LVL_W-1:0]       level_ff, level_in;

   always_comb begin
      wr_ptr_in = push.valid ? p2c_pkg::PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? p2c_pkg::PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push.valid && !pop) begin
         level_in = p2c_pkg::LVL_W'(level_ff + 1'b1);
      end else if (pop && !push.valid) begin
         level_in = p2c_pkg::LVL_W'(level_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign head_valid = level_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ===== rtl/p2c_back.sv =====
// back end: unpacks a changed chunk into four pixel words behind an output register
module p2c_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  p2c_pkg::p2c_job_type       head,
   input  logic [p2c_pkg::ADDR_W-1:0] frame_offset,
   output logic                       pop,
   p2c_rsp_if.source                  rsp
);

   p2c_pkg::p2c_job_type       cur_ff;
   logic                       cur_valid_ff, cur_valid_in;
   logic [1:0]                 word_ff, word_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [p2c_pkg::ADDR_W-1:0] byte_address_ff;
   logic [31:0]                pixel_quad_ff;
   logic                       last_word_ff;

   logic                       out_load;
   logic                       final_word;

   assign out_load   = cur_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign final_word = word_ff == 2'd3;
   assign pop        = head_valid && (!cur_valid_ff || (out_load && final_word));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
      end else if (out_load && final_word) begin
         cur_valid_in = 1'b0;
      end
      word_in      = out_load ? 2'(word_ff + 1'b1) : word_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      if (out_load) begin
         byte_address_ff <= frame_offset + cur_ff.line_offset + cur_ff.col_offset
                            + p2c_pkg::ADDR_W'({word_ff, 2'b00});
         pixel_quad_ff   <= p2c_pkg::chunky_quad(cur_ff.plane_pair_a, cur_ff.plane_pair_b,
                                                 word_ff);
         last_word_ff    <= final_word;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.byte_address = byte_address_ff;
   assign rsp.pixel_quad   = pixel_quad_ff;
   assign rsp.last_word    = last_word_ff;

endmodule

// ===== rtl/planar_to_chunky_dirty_blit_unit.sv =====
// top level of the planar to chunky blitter with change detection
// Each item on req_chan is one 16-pixel chunk of a 4-bitplane screen. The unit tracks the chunk
// position (column, line; frame_start restarts it) and keeps the last chunk seen at each
// position in a CHUNKS_PER_LINE*LINES x 64 history ram. An unchanged chunk produces nothing and,
// while the job queue is empty, the next item is taken in the following cycle, so unchanged
// chunks then stream at one per cycle. A changed chunk produces four pixel words on rsp_chan,
// one per cycle from the output register while rsp_chan is ready; the writer's single output
// word per cycle limits how fast changed chunks are taken. The first word passes the history
// ram registered read, the job queue, the writer's current-job register and the output register.
// The history ram has no clearing pass: a fill mark tracks how far positions have been
// visited since reset, entries at or past it read as zero, so items are taken straight out of
// reset. Registers: index 0 frame_offset, index 1 line_bytes; writes to other indexes are dropped.
module planar_to_chunky_dirty_blit_unit #(
   parameter int CHUNKS_PER_LINE = 20,
   parameter int LINES           = 200
) (
   input  logic       clock,
   input  logic       reset,
   p2c_req_if.sink    req_chan,
   p2c_rsp_if.source  rsp_chan,
   p2c_csr_if.sink    csr_chan
);

   // configuration registers
   logic [p2c_pkg::ADDR_W-1:0] frame_offset_ff, frame_offset_in;
   logic [p2c_pkg::LB_W-1:0]   line_bytes_ff, line_bytes_in;
   logic                       csr_fire;

   // front to back
   p2c_pkg::p2c_push_type      push;
   p2c_pkg::p2c_job_type       head;
   logic                       head_valid;
   logic                       pop;
   logic [p2c_pkg::LVL_W-1:0]  queue_level;

   // register port never stalls
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   always_comb begin
      frame_offset_in = frame_offset_ff;
      line_bytes_in   = line_bytes_ff;
      if (csr_fire) begin
         case (csr_chan.reg_index)
            p2c_pkg::CSR_FRAME_OFFSET: begin
               frame_offset_in = csr_chan.write_data[p2c_pkg::ADDR_W-1:0];
            end
            p2c_pkg::CSR_LINE_BYTES: begin
               line_bytes_in = csr_chan.write_data[p2c_pkg::LB_W-1:0];
            end
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_offset_ff <= '0;
         line_bytes_ff   <= p2c_pkg::LINE_BYTES_RESET;
      end else begin
         frame_offset_ff <= frame_offset_in;
         line_bytes_ff   <= line_bytes_in;
      end
   end

   // classify: position, history lookup and compare, pushes changed chunks only
   p2c_front #(
      .CHUNKS_PER_LINE(CHUNKS_PER_LINE),
      .LINES          (LINES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .line_bytes (line_bytes_ff),
      .queue_level(queue_level),
      .push       (push)
   );

   // two-entry job queue decouples classification from word output
   p2c_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head_valid(head_valid),
      .head      (head),
      .level     (queue_level)
   );

   // writer: four words per job
   p2c_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .frame_offset(frame_offset_ff),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

   // front only pushes when the queue has room
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (queue_level < p2c_pkg::QDEPTH))
      else $error("job queue overflow");

   // the words of one chunk follow each other without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_word) |=> rsp_chan.valid)
      else $error("gap inside a changed chunk");

   // nothing left on the output after reset
   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("output valid after reset");

endmodule
